FILE: design/trc_pkg.sv
// Package for the texture residency cache: operation codes, sequencer states,
// request, entry and result types shared by the modules.
// No dependencies.
package trc_pkg;

  // Default number of table slots
  localparam int TRC_TABLE_ENTRIES = 16;

  // Reset value of the garbage collection age limit
  localparam logic [31:0] TRC_MAX_AGE_RESET = 32'd60;

  // Operation codes
  localparam logic [1:0] FUNC_LOOKUP  = 2'd0;
  localparam logic [1:0] FUNC_COLLECT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_CLOSE
  } trc_state_t;

  // One input item
  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [10:0] tex_width;
    logic [10:0] tex_height;
    logic [3:0]  tex_mode;
    logic [31:0] update_count;
    logic [31:0] frame_number;
    logic [31:0] offered_handle;
  } trc_req_t;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [31:0] address;
    logic [10:0] width;
    logic [10:0] height;
    logic [3:0]  mode;
    logic [31:0] handle;
    logic [31:0] updates;
    logic [31:0] last_frame;
  } trc_entry_t;

  // Compare unit flags for one entry against the current item
  typedef struct packed {
    logic addr_eq;
    logic geom_eq;
    logic upd_gt;
    logic aged;
  } trc_cmp_t;

  // One result item
  typedef struct packed {
    logic [31:0] result_handle;
    logic        push_data;
    logic        used_offer;
    logic        release_valid;
    logic [31:0] release_handle;
    logic        table_full;
    logic        last;
  } trc_result_t;

endpackage

FILE: design/trc_ifs.sv
// Valid/ready channel interfaces of the texture residency cache: request,
// result and configuration write. Depends on nothing.
interface trc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] address;
  logic [10:0] tex_width;
  logic [10:0] tex_height;
  logic [3:0]  tex_mode;
  logic [31:0] update_count;
  logic [31:0] frame_number;
  logic [31:0] offered_handle;

  modport source (
    output valid, func, address, tex_width, tex_height, tex_mode,
           update_count, frame_number, offered_handle,
    input  ready
  );
  modport sink (
    input  valid, func, address, tex_width, tex_height, tex_mode,
           update_count, frame_number, offered_handle,
    output ready
  );
endinterface

interface trc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_handle;
  logic        push_data;
  logic        used_offer;
  logic        release_valid;
  logic [31:0] release_handle;
  logic        table_full;
  logic        last;

  modport source (
    output valid, result_handle, push_data, used_offer, release_valid,
           release_handle, table_full, last,
    input  ready
  );
  modport sink (
    input  valid, result_handle, push_data, used_offer, release_valid,
           release_handle, table_full, last,
    output ready
  );
endinterface

interface trc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_age;

  modport source (output valid, max_age, input ready);
  modport sink (input valid, max_age, output ready);
endinterface

FILE: design/trc_cmp.sv
// Shared compare unit: matches one table entry against the current item and
// checks its age. Depends on trc_pkg.
module trc_cmp
  import trc_pkg::*;
(
  input  trc_entry_t  entry,
  input  trc_req_t    req,
  input  logic [31:0] max_age,
  output trc_cmp_t    flags
);

  logic [31:0] age;

  // Wrapping frame distance since last use
  assign age = req.frame_number - entry.last_frame;

  // Key, geometry, update count and age compares
  always_comb begin
    flags.addr_eq = (entry.address == req.address);
    flags.geom_eq = (entry.width == req.tex_width) && (entry.height == req.tex_height)
                    && (entry.mode == req.tex_mode);
    flags.upd_gt  = (req.update_count > entry.updates);
    flags.aged    = (age > max_age);
  end

endmodule

FILE: design/texture_residency_cache.sv
// Top level of the texture residency cache: sequencer, entry memory, valid
// bits, output register. Depends on trc_pkg, trc_ifs and trc_cmp.
//
// A table of TABLE_ENTRIES texture slots keyed by video memory address. Every
// item walks the entry memory through its single read port, one slot per
// cycle unless a release waits for the result register, with the shared
// compare unit checking each slot. The block takes no new item until it is
// idle again. A lookup scans every slot and then has one decision step that
// may write a slot and loads the single result once the result register is
// free. Collect and clear scan every slot and then have a closing step that
// loads the closing item; the scan or the closing step holds while the result
// register is still occupied. They give one item per released slot in slot
// order and then a closing item with last set. An unknown func goes straight
// to the closing step and gives one closing item with only last set. The
// max_age register may be written at any time the block is idle; reset sets
// it to 60.
module texture_residency_cache
  import trc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TRC_TABLE_ENTRIES
) (
  input  logic   clk,
  input  logic   rst,
  trc_req_if.sink   req,
  trc_rsp_if.source rsp,
  trc_cfg_if.sink   cfg
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  trc_state_t state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [31:0] max_age;

  trc_req_t   req_q;
  trc_req_t   req_in;
  trc_entry_t mem [TABLE_ENTRIES];
  trc_entry_t rd_data;
  trc_cmp_t   cmp;

  // Lookup scan results
  logic             found_hit;
  logic [IDX_W-1:0] found_idx;
  trc_entry_t       found_entry;
  trc_cmp_t         found_cmp;
  logic             free_hit;
  logic [IDX_W-1:0] free_idx;

  // Output register
  logic        o_valid;
  trc_result_t o_data;
  trc_result_t o_next;
  logic        o_load;
  logic        can_emit;

  // Datapath controls
  logic             advance;
  logic             scan_emit;
  logic             scan_end;
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  trc_entry_t       wr_data;
  logic             vld_wr_en;
  logic             vld_wr_val;
  logic [IDX_W-1:0] vld_wr_idx;
  logic             accept;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign can_emit = !o_valid || rsp.ready;

  // Gather the incoming item
  always_comb begin
    req_in.func           = req.func;
    req_in.address        = req.address;
    req_in.tex_width      = req.tex_width;
    req_in.tex_height     = req.tex_height;
    req_in.tex_mode       = req.tex_mode;
    req_in.update_count   = req.update_count;
    req_in.frame_number   = req.frame_number;
    req_in.offered_handle = req.offered_handle;
  end

  trc_cmp u_cmp (
    .entry   (rd_data),
    .req     (req_q),
    .max_age (max_age),
    .flags   (cmp)
  );

  // Scan stepping: lookups never stall, releases wait for the result register
  always_comb begin
    scan_emit = 1'b0;
    advance   = 1'b0;
    if (state == ST_SCAN) begin
      if (req_q.func == FUNC_LOOKUP) begin
        advance = 1'b1;
      end else if (valid[idx] && (req_q.func == FUNC_CLEAR || cmp.aged)) begin
        scan_emit = 1'b1;
        advance   = can_emit;
      end else begin
        advance = 1'b1;
      end
    end
    scan_end = advance && (idx == LAST_IDX);
  end

  // Next state and next slot index
  always_comb begin
    state_next = state;
    idx_next   = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.func inside {FUNC_LOOKUP, FUNC_COLLECT, FUNC_CLEAR}) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = (req_q.func == FUNC_LOOKUP) ? ST_DECIDE : ST_CLOSE;
        end else if (advance) begin
          idx_next = idx + 1'b1;
        end else begin
          idx_next = idx;
        end
      end
      ST_DECIDE: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result, memory write and valid bit controls
  always_comb begin
    o_load     = 1'b0;
    o_next     = '0;
    wr_en      = 1'b0;
    wr_idx     = found_idx;
    wr_data.address    = req_q.address;
    wr_data.width      = req_q.tex_width;
    wr_data.height     = req_q.tex_height;
    wr_data.mode       = req_q.tex_mode;
    wr_data.handle     = req_q.offered_handle;
    wr_data.updates    = req_q.update_count;
    wr_data.last_frame = req_q.frame_number;
    vld_wr_en  = 1'b0;
    vld_wr_val = 1'b0;
    vld_wr_idx = idx;
    case (state)
      ST_SCAN: begin
        // Release one slot
        if (scan_emit && can_emit) begin
          o_load                = 1'b1;
          o_next.release_valid  = 1'b1;
          o_next.release_handle = rd_data.handle;
          vld_wr_en             = 1'b1;
        end
      end
      ST_DECIDE: begin
        o_load      = can_emit;
        o_next.last = 1'b1;
        vld_wr_idx  = found_idx;
        if (found_hit && found_cmp.geom_eq) begin
          // Hit: refresh frame, take the newer update count
          wr_en              = can_emit;
          wr_data            = found_entry;
          wr_data.last_frame = req_q.frame_number;
          if (found_cmp.upd_gt) begin
            wr_data.updates = req_q.update_count;
          end
          o_next.result_handle = found_entry.handle;
          o_next.push_data     = found_cmp.upd_gt;
        end else if (found_hit) begin
          // Mismatch: release the old handle, recreate in place if offered
          o_next.release_valid  = 1'b1;
          o_next.release_handle = found_entry.handle;
          vld_wr_en             = can_emit;
          if (req_q.offered_handle != '0) begin
            wr_en                = can_emit;
            vld_wr_val           = 1'b1;
            o_next.result_handle = req_q.offered_handle;
            o_next.push_data     = 1'b1;
            o_next.used_offer    = 1'b1;
          end
        end else if (!free_hit) begin
          o_next.table_full = 1'b1;
        end else if (req_q.offered_handle != '0) begin
          // Miss: create in the lowest free slot
          wr_en                = can_emit;
          wr_idx               = free_idx;
          vld_wr_en            = can_emit;
          vld_wr_val           = 1'b1;
          vld_wr_idx           = free_idx;
          o_next.result_handle = req_q.offered_handle;
          o_next.push_data     = 1'b1;
          o_next.used_offer    = 1'b1;
        end
      end
      ST_CLOSE: begin
        o_load      = can_emit;
        o_next.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, valid bits, configuration and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      valid   <= '0;
      max_age <= TRC_MAX_AGE_RESET;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (vld_wr_en) begin
        valid[vld_wr_idx] <= vld_wr_val;
      end
      if (cfg.valid && cfg.ready) begin
        max_age <= cfg.max_age;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  // Entry memory: read the slot the scan visits next, write on decision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[idx_next];
  end

  // Item capture, lookup tracking and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_in;
    end
    if (rst || accept) begin
      found_hit <= 1'b0;
      free_hit  <= 1'b0;
    end else if (state == ST_SCAN && req_q.func == FUNC_LOOKUP) begin
      if (valid[idx] && cmp.addr_eq && !found_hit) begin
        found_hit   <= 1'b1;
        found_idx   <= idx;
        found_entry <= rd_data;
        found_cmp   <= cmp;
      end
      if (!valid[idx] && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= idx;
      end
    end
    if (o_load) begin
      o_data <= o_next;
    end
  end

  // Drive the result channel
  assign rsp.valid          = o_valid;
  assign rsp.result_handle  = o_data.result_handle;
  assign rsp.push_data      = o_data.push_data;
  assign rsp.used_offer     = o_data.used_offer;
  assign rsp.release_valid  = o_data.release_valid;
  assign rsp.release_handle = o_data.release_handle;
  assign rsp.table_full     = o_data.table_full;
  assign rsp.last           = o_data.last;

  // A stored entry always carries a live handle
  a_wr_handle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> wr_data.handle != '0)
    else $error("entry written with a zero handle");

  // Release items from the scan are never the closing item
  a_scan_not_last: assert property (@(posedge clk) disable iff (rst)
    (o_load && state == ST_SCAN) |-> !o_next.last && o_next.release_valid)
    else $error("scan result malformed");

  // Collect and clear never add entries
  a_scan_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && req_q.func != FUNC_LOOKUP)
    |=> $countones(valid) <= $past($countones(valid)))
    else $error("valid entries grew during release scan");

  // The decision cycle ends the item once the result register takes it
  a_decide_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && can_emit) |=> state == ST_IDLE && o_valid && o_data.last)
    else $error("lookup did not complete");

  // A released slot is cleared in the same step
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (o_load && state == ST_SCAN) |=> !valid[$past(idx)])
    else $error("released slot still valid");

endmodule
